// ----- rtl/core/command_keyword_matcher_core_macros.svh -----
// assertion macros used by the matcher core rtl
`ifndef COMMAND_KEYWORD_MATCHER_CORE_MACROS_SVH
`define COMMAND_KEYWORD_MATCHER_CORE_MACROS_SVH

// property that holds in the same cycle, checked on clk, off during rst
`define CKM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CKM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ckm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ckm_pkg;

  localparam int NUM_COMMANDS = 28;
  localparam int MAX_NAME_LEN = 16;
  localparam int LINE_MAX     = 256;

  localparam int IDX_W     = 5;
  localparam int POS_W     = 5;
  localparam int CPOS_W    = 8;
  localparam int NAME_BITS = MAX_NAME_LEN * 8;

  localparam logic [POS_W-1:0]  NAME_POS_MAX = POS_W'(MAX_NAME_LEN);
  localparam logic [CPOS_W-1:0] CHAR_POS_CAP =
    CPOS_W'((LINE_MAX - 1 < 255) ? (LINE_MAX - 1) : 255);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // names right-justified in their slot, zero filled above
  localparam logic [NAME_BITS-1:0] CMD_NAMES [NUM_COMMANDS] = '{
    "*IDN?", "*RST", "*OPC?", "READ?", "MEAS:FREQ?", "CONF:FREQ?",
    "CONF:FREQ", "FREQ:GATE:TIME?", "FREQ:GATE:TIME", "PPM?", "PPM",
    "STARTUP:SPAN?", "STARTUP:SPAN", "STARTUP:WIN?", "STARTUP:WIN",
    "STARTUP:INIT", "STARTUP:TIME?", "SIG:PRIREF", "SIG:REFCLOCK",
    "SIG:OCXO", "SIG:STATUS0?", "SIG:STATUS1?", "SIG:STARTT?",
    "CAL:REF:PREP", "CAL:REF:LOCK", "CAL:REF:VAL?", "CAL:REF?", "CAL:TDC?"
  };

  localparam logic [POS_W-1:0] NAME_LEN [NUM_COMMANDS] = '{
    5'd5, 5'd4, 5'd5, 5'd5, 5'd10, 5'd10,
    5'd9, 5'd15, 5'd14, 5'd4, 5'd3,
    5'd13, 5'd12, 5'd12, 5'd11,
    5'd12, 5'd13, 5'd10, 5'd12,
    5'd8, 5'd12, 5'd12, 5'd11,
    5'd12, 5'd12, 5'd12, 5'd8, 5'd8
  };

  // result of one compare step against all names
  typedef struct packed {
    logic [NUM_COMMANDS-1:0] alive;
    logic                    hit;
    logic [IDX_W-1:0]        index;
  } ckm_cmp_t;

  // character of name idx at position pos, zero past its end
  function automatic logic [7:0] name_char(input int idx, input logic [POS_W-1:0] pos);
    logic [7:0] ch;
    int         sh;
    ch = CH_NUL;
    sh = 8 * (int'(NAME_LEN[idx]) - 1 - int'(pos));
    if (pos < NAME_LEN[idx]) begin
      ch = CMD_NAMES[idx][sh +: 8];
    end
    return ch;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      u = c - 8'h20;
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/command_keyword_matcher_core.sv -----
// timing: an accepted character is held in the input register and processed from there; an
//   end-of-line character loads its result onto m_tvalid, waiting while a result is unread
// throughput: one character per cycle through the parallel name compare; a stalled result
//   holds end-of-line characters back, and with them the characters queued behind them
// reset: rst is synchronous, active high; clears the line state and both valid flags
`timescale 1ns / 1ps
`default_nettype none
`include "command_keyword_matcher_core_macros.svh"

module command_keyword_matcher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // character requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  // result requests
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [0] matched, [5:1] command_index,
                                      // [13:6] arg_offset, [15:14] zero
);
  import ckm_pkg::*;

  typedef enum logic [1:0] {PH_LEAD, PH_NAME, PH_GAP, PH_REST} phase_t;

  // input register
  logic                    in_valid;
  logic [7:0]              in_char;

  // line state
  phase_t                  phase;
  logic [POS_W-1:0]        name_position;
  logic [NUM_COMMANDS-1:0] alive_mask;
  logic [IDX_W-1:0]        found_index;
  logic                    found_flag;
  logic [CPOS_W-1:0]       char_position;
  logic [CPOS_W-1:0]       arg_start;

  // result register
  logic                    out_matched;
  logic [IDX_W-1:0]        out_index;
  logic [CPOS_W-1:0]       out_offset;

  // next values
  phase_t                  phase_next;
  logic [POS_W-1:0]        name_position_next;
  logic [NUM_COMMANDS-1:0] alive_mask_next;
  logic [IDX_W-1:0]        found_index_next;
  logic                    found_flag_next;
  logic [CPOS_W-1:0]       char_position_next;
  logic [CPOS_W-1:0]       arg_start_next;

  ckm_cmp_t cmp;
  logic     is_space;
  logic     is_eol;
  logic     consumed;
  logic     emit;
  logic     out_free;
  logic     step;

  ckm_name_cmp u_cmp (
    .char_code (in_char),
    .name_pos  (name_position),
    .alive     (alive_mask),
    .cmp       (cmp)
  );

  assign is_space = (in_char == CH_SPACE);
  assign is_eol   = (in_char == CH_NUL) || (in_char == CH_CR) || (in_char == CH_LF);

  // one character walks through the phases it can pass in a single step
  always_comb begin
    phase_next         = phase;
    name_position_next = name_position;
    alive_mask_next    = alive_mask;
    found_index_next   = found_index;
    found_flag_next    = found_flag;
    arg_start_next     = arg_start;
    consumed           = 1'b0;
    emit               = 1'b0;

    if (phase_next == PH_LEAD) begin
      if (is_space) begin
        consumed = 1'b1;
      end else begin
        phase_next = PH_NAME;
      end
    end

    if (!consumed && phase_next == PH_NAME) begin
      if (is_space || is_eol) begin
        // name ended: pick the first live name of exactly this length
        found_flag_next  = cmp.hit;
        found_index_next = cmp.index;
        phase_next       = cmp.hit ? PH_GAP : PH_REST;
      end else begin
        alive_mask_next = cmp.alive;
        if (name_position < NAME_POS_MAX) begin
          name_position_next = name_position + POS_W'(1);
        end
        consumed = 1'b1;
      end
    end

    if (!consumed && phase_next == PH_GAP) begin
      if (is_space) begin
        consumed = 1'b1;
      end else begin
        arg_start_next = char_position;
        phase_next     = PH_REST;
      end
    end

    if (!consumed) begin
      if (is_eol) begin
        emit = 1'b1;
      end else begin
        consumed = 1'b1;
      end
    end

    // saturating line position
    char_position_next = char_position;
    if (consumed && char_position < CHAR_POS_CAP) begin
      char_position_next = char_position + CPOS_W'(1);
    end
  end

  // a non-emitting character never waits on the result side
  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      phase         <= PH_LEAD;
      name_position <= '0;
      alive_mask    <= '1;
      found_index   <= '0;
      found_flag    <= 1'b0;
      char_position <= '0;
      arg_start     <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_char  <= s_tdata;
      end else if (step) begin
        in_valid <= 1'b0;
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (step) begin
        if (emit) begin
          m_tvalid      <= 1'b1;
          out_matched   <= found_flag_next;
          out_index     <= found_flag_next ? found_index_next : '0;
          out_offset    <= found_flag_next ? arg_start_next : '0;
          // back to the start of a fresh line
          phase         <= PH_LEAD;
          name_position <= '0;
          alive_mask    <= '1;
          found_index   <= '0;
          found_flag    <= 1'b0;
          char_position <= '0;
          arg_start     <= '0;
        end else begin
          phase         <= phase_next;
          name_position <= name_position_next;
          alive_mask    <= alive_mask_next;
          found_index   <= found_index_next;
          found_flag    <= found_flag_next;
          char_position <= char_position_next;
          arg_start     <= arg_start_next;
        end
      end
    end
  end

  assign m_tdata = {2'b00, out_offset, out_index, out_matched};

  // a matched index always points into the table
  `CKM_ASSERT(a_index_range, !m_tvalid || !m_tdata[0] || (m_tdata[5:1] < IDX_W'(NUM_COMMANDS)), "command index out of table")
  // a miss carries zero index and offset
  `CKM_ASSERT(a_miss_zero, !m_tvalid || m_tdata[0] || (m_tdata[13:1] == 13'd0), "miss result not zeroed")
  // a found name only exists after the name phase
  `CKM_ASSERT(a_found_phase, !found_flag || phase == PH_GAP || phase == PH_REST, "found flag in wrong phase")
  // an emitted result restarts the line
  `CKM_ASSERT_NEXT(a_line_restart, step && emit, phase == PH_LEAD && char_position == '0 && m_tvalid, "line state not restarted after result")

endmodule

`default_nettype wire

// ----- rtl/core/ckm_name_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ckm_name_cmp (
  input  wire logic [7:0]                        char_code,
  input  wire logic [ckm_pkg::POS_W-1:0]         name_pos,
  input  wire logic [ckm_pkg::NUM_COMMANDS-1:0]  alive,
  output ckm_pkg::ckm_cmp_t                      cmp
);
  import ckm_pkg::*;

  logic [7:0] upper;

  assign upper = fold_upper(char_code);

  always_comb begin
    cmp.alive = alive;
    cmp.hit   = 1'b0;
    cmp.index = '0;
    // narrow the live set on this character
    for (int i = 0; i < NUM_COMMANDS; i++) begin
      if (name_char(i, name_pos) != upper) begin
        cmp.alive[i] = 1'b0;
      end
    end
    // lowest live name that ends here wins
    for (int i = NUM_COMMANDS - 1; i >= 0; i--) begin
      if (alive[i] && name_pos >= NAME_LEN[i]) begin
        cmp.hit   = 1'b1;
        cmp.index = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire
